[design/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the byte-level I2C master engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// command codes carried in the opcode field
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_WACK  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// ack poll limit after reset
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// one bus tick
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_in;
	} req_t;

	// line state and status after one tick
	typedef struct packed {
		logic       scl;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_failed;
	} rsp_t;

endpackage

[design/i2c_master_byte_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Tick-driven I2C master: start, stop, byte write, ack wait, byte read.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): one transaction per bus tick,
//   carrying an optional command and the sampled SDA level. Commands with a
//   known opcode are taken only while no command is running; others are dropped.
//   rsp channel (rsp_valid/rsp_stall/rsp): one transaction per tick with the
//   SCL/SDA line registers, busy, done, last read byte and ack failure flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the ack poll limit;
//   always ready, write only while the engine is idle.
// Timing:
//   The tick lands in an input register, then the engine evaluates it and
//   loads the result register when the stage advances.
//   Throughput is one tick per cycle while rsp_stall is low; the result register
//   and input register let a new tick enter while a result waits to be taken.
// Reset:
//   Lines go to SCL high, SDA high and driven, engine idle, limit 250.
// Stall:
//   A stalled result holds; once both registers are full, req_stall rises.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  i2cm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output i2cm_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data
);
	import i2cm_pkg::*;

	req_t req_s1;
	logic valid_s1;
	logic rsp_valid_q;
	logic advance;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload register: load a valid tick whenever the stage is free
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	i2cm_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.req      (req_s1),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

endmodule

[design/i2cm_engine.sv]
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: advances the command state by one tick per registered item
// and holds the line registers and status that form the result.
// ----------------------------------------------------------------------------
module i2cm_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  i2cm_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_data,
	output i2cm_pkg::rsp_t rsp
);
	import i2cm_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_STOP,
		PH_WRITE,
		PH_WACK,
		PH_READ,
		PH_RACK
	} phase_t;

	phase_t     phase_q,  phase_d;
	logic [4:0] tick_q,   tick_d;
	logic [2:0] bit_q,    bit_d;
	logic [7:0] shift_q,  shift_d;
	logic [7:0] poll_q,   poll_d;
	logic       scl_q,    scl_d;
	logic       sda_q,    sda_d;
	logic       drv_q,    drv_d;
	logic       ackc_q,   ackc_d;
	logic [7:0] last_q,   last_d;
	logic       fail_q,   fail_d;
	logic       busy_d,   done_d;
	logic       busy_q,   done_q;
	logic [7:0] ack_timeout_q;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		drv_d   = drv_q;
		ackc_d  = ackc_q;
		last_d  = last_q;
		fail_d  = fail_q;
		done_d  = 1'b0;

		// take a new command only when idle
		if (phase_q == PH_IDLE && req.cmd_valid && req.opcode <= OP_READ) begin
			tick_d = 5'd0;
			bit_d  = 3'd0;
			poll_d = 8'd0;
			case (req.opcode)
				OP_START: phase_d = PH_START;
				OP_STOP:  phase_d = PH_STOP;
				OP_WRITE: begin
					phase_d = PH_WRITE;
					shift_d = req.write_data;
				end
				OP_WACK: begin
					phase_d = PH_WACK;
					fail_d  = 1'b0;
				end
				default: begin
					phase_d = PH_READ;
					shift_d = 8'd0;
					ackc_d  = req.send_ack;
				end
			endcase
		end

		busy_d = (phase_d != PH_IDLE);

		case (phase_d)
			PH_START: begin
				if (tick_d == 5'd0) begin
					drv_d = 1'b1;
					sda_d = 1'b1;
				end else if (tick_d == 5'd5) begin
					scl_d = 1'b1;
				end else if (tick_d == 5'd10) begin
					sda_d = 1'b0;
				end else if (tick_d == 5'd15) begin
					scl_d = 1'b0;
				end
				if (tick_d >= 5'd19) begin
					phase_d = PH_IDLE;
					tick_d  = 5'd0;
					bit_d   = 3'd0;
					done_d  = 1'b1;
				end else begin
					tick_d = tick_d + 5'd1;
				end
			end
			PH_STOP: begin
				if (tick_d == 5'd0) begin
					drv_d = 1'b1;
				end else if (tick_d == 5'd5) begin
					scl_d = 1'b0;
				end else if (tick_d == 5'd10) begin
					sda_d = 1'b0;
				end else if (tick_d == 5'd15) begin
					scl_d = 1'b1;
				end else if (tick_d == 5'd20) begin
					sda_d = 1'b1;
				end
				if (tick_d >= 5'd23) begin
					phase_d = PH_IDLE;
					tick_d  = 5'd0;
					bit_d   = 3'd0;
					done_d  = 1'b1;
				end else begin
					tick_d = tick_d + 5'd1;
				end
			end
			PH_WRITE: begin
				if (tick_d == 5'd0) begin
					drv_d   = 1'b1;
					scl_d   = 1'b0;
					sda_d   = shift_d[7];
					shift_d = {shift_d[6:0], 1'b0};
				end else if (tick_d == 5'd2) begin
					scl_d = 1'b1;
				end else if (tick_d == 5'd8) begin
					scl_d = 1'b0;
				end
				if (tick_d >= 5'd9) begin
					tick_d = 5'd0;
					if (bit_d == 3'd7) begin
						phase_d = PH_IDLE;
						bit_d   = 3'd0;
						done_d  = 1'b1;
					end else begin
						bit_d = bit_d + 3'd1;
					end
				end else begin
					tick_d = tick_d + 5'd1;
				end
			end
			PH_WACK: begin
				if (tick_d == 5'd0) begin
					drv_d  = 1'b0;
					sda_d  = 1'b1;
					tick_d = 5'd1;
				end else if (tick_d == 5'd1) begin
					scl_d  = 1'b1;
					tick_d = 5'd2;
				end else if (!req.sda_in) begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					tick_d  = 5'd0;
					bit_d   = 3'd0;
					done_d  = 1'b1;
				end else if (poll_d >= ack_timeout_q) begin
					// no ack: flag it and release the bus with a stop
					fail_d  = 1'b1;
					phase_d = PH_STOP;
					tick_d  = 5'd0;
				end else begin
					poll_d = poll_d + 8'd1;
				end
			end
			PH_READ: begin
				if (tick_d == 5'd0) begin
					drv_d = 1'b0;
					scl_d = 1'b0;
				end
				if (tick_d >= 5'd2) begin
					scl_d   = 1'b1;
					shift_d = {shift_d[6:0], req.sda_in};
					tick_d  = 5'd0;
					if (bit_d == 3'd7) begin
						phase_d = PH_RACK;
						bit_d   = 3'd0;
					end else begin
						bit_d = bit_d + 3'd1;
					end
				end else begin
					tick_d = tick_d + 5'd1;
				end
			end
			PH_RACK: begin
				if (tick_d == 5'd0) begin
					scl_d = 1'b0;
					drv_d = 1'b1;
					sda_d = !ackc_d;
				end else if (tick_d == 5'd2) begin
					scl_d = 1'b1;
				end
				if (tick_d >= 5'd4) begin
					scl_d   = 1'b0;
					last_d  = shift_d;
					phase_d = PH_IDLE;
					tick_d  = 5'd0;
					bit_d   = 3'd0;
					done_d  = 1'b1;
				end else begin
					tick_d = tick_d + 5'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			tick_q        <= 5'd0;
			bit_q         <= 3'd0;
			shift_q       <= 8'd0;
			poll_q        <= 8'd0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			drv_q         <= 1'b1;
			ackc_q        <= 1'b0;
			last_q        <= 8'd0;
			fail_q        <= 1'b0;
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else begin
			if (cfg_we) begin
				ack_timeout_q <= cfg_data;
			end
			if (advance) begin
				phase_q <= phase_d;
				tick_q  <= tick_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				poll_q  <= poll_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				drv_q   <= drv_d;
				ackc_q  <= ackc_d;
				last_q  <= last_d;
				fail_q  <= fail_d;
				busy_q  <= busy_d;
				done_q  <= done_d;
			end
		end
	end

	assign rsp.scl        = scl_q;
	assign rsp.sda_level  = sda_q;
	assign rsp.sda_drive  = drv_q;
	assign rsp.busy_res   = busy_q;
	assign rsp.done_res   = done_q;
	assign rsp.read_data  = last_q;
	assign rsp.ack_failed = fail_q;

endmodule

[design/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master, attached to the top level by bind.
// ----------------------------------------------------------------------------
module i2cm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input i2cm_pkg::rsp_t rsp
);
	import i2cm_pkg::*;

	// a completing tick is always part of a command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.done_res |-> rsp.busy_res)
		else $error("done without busy");

	// after a failed ack the bus ends driven once idle
	a_fail_driven: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ack_failed && !rsp.busy_res |-> rsp.sda_drive)
		else $error("SDA released after failed ack");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed under stall");

	// input stalls only with a pending result held up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

[verif/tb_i2c_master_byte_engine.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Self-checking bench for the tick-driven I2C master. Every bus tick is sent
// as one req transaction and mirrored in a behavioral model of the engine;
// each rsp transaction is compared field by field with the oldest prediction.
// Directed tests cover each command, the ack poll limits and dropped
// commands; random command streams run under three idling mixes.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_TICKS = 30;

	typedef enum logic [2:0] {
		ENG_IDLE, ENG_START, ENG_STOP, ENG_WRITE, ENG_WACK, ENG_READ, ENG_RACK
	} eng_phase_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;

	// engine model state
	eng_phase_t eng_phase;
	logic [7:0] tick_cnt;
	logic [3:0] bit_cnt;
	logic [7:0] shift_reg;
	logic [7:0] poll_cnt;
	logic       scl_q, sda_q, drv_q;
	logic       ack_sel;
	logic [7:0] read_byte;
	logic       ack_fail;
	logic       done_flag;
	logic [7:0] ack_limit;

	rsp_t expected_bus_q[$];
	rsp_t want;
	int   mismatch_cnt = 0;
	int   ticks_sent = 0;
	int   cycle_cnt = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   rx_hold = 0;

	i2c_master_byte_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void end_command();
		eng_phase = ENG_IDLE;
		tick_cnt = '0;
		bit_cnt = '0;
		done_flag = 1'b1;
	endfunction

	// advance the engine model by one tick and return the line/status word
	function automatic rsp_t step_engine(input req_t r);
		rsp_t o;
		logic [7:0] t;
		done_flag = 1'b0;
		if (eng_phase == ENG_IDLE && r.cmd_valid && r.opcode <= OP_READ) begin
			tick_cnt = '0;
			bit_cnt = '0;
			poll_cnt = '0;
			case (r.opcode)
				OP_START: eng_phase = ENG_START;
				OP_STOP:  eng_phase = ENG_STOP;
				OP_WRITE: begin
					eng_phase = ENG_WRITE;
					shift_reg = r.write_data;
				end
				OP_WACK: begin
					eng_phase = ENG_WACK;
					ack_fail = 1'b0;
				end
				default: begin
					eng_phase = ENG_READ;
					shift_reg = '0;
					ack_sel = r.send_ack;
				end
			endcase
		end
		o.busy_res = (eng_phase != ENG_IDLE);
		t = tick_cnt;
		case (eng_phase)
			ENG_START: begin
				if (t == 0) begin
					drv_q = 1'b1;
					sda_q = 1'b1;
				end else if (t == 5) scl_q = 1'b1;
				else if (t == 10) sda_q = 1'b0;
				else if (t == 15) scl_q = 1'b0;
				if (t >= 19) end_command();
				else tick_cnt = t + 8'd1;
			end
			ENG_STOP: begin
				if (t == 0) drv_q = 1'b1;
				else if (t == 5) scl_q = 1'b0;
				else if (t == 10) sda_q = 1'b0;
				else if (t == 15) scl_q = 1'b1;
				else if (t == 20) sda_q = 1'b1;
				if (t >= 23) end_command();
				else tick_cnt = t + 8'd1;
			end
			ENG_WRITE: begin
				if (t == 0) begin
					drv_q = 1'b1;
					scl_q = 1'b0;
					sda_q = shift_reg[7];
					shift_reg = {shift_reg[6:0], 1'b0};
				end else if (t == 2) scl_q = 1'b1;
				else if (t == 8) scl_q = 1'b0;
				if (t >= 9) begin
					tick_cnt = '0;
					if (bit_cnt >= 7) end_command();
					else bit_cnt++;
				end else tick_cnt = t + 8'd1;
			end
			ENG_WACK: begin
				if (t == 0) begin
					drv_q = 1'b0;
					sda_q = 1'b1;
					tick_cnt = 8'd1;
				end else if (t == 1) begin
					scl_q = 1'b1;
					tick_cnt = 8'd2;
				end else if (!r.sda_in) begin
					scl_q = 1'b0;
					end_command();
				end else if (poll_cnt >= ack_limit) begin
					// poll limit exceeded: flag it and release the bus with a stop
					ack_fail = 1'b1;
					eng_phase = ENG_STOP;
					tick_cnt = '0;
				end else poll_cnt++;
			end
			ENG_READ: begin
				if (t == 0) begin
					drv_q = 1'b0;
					scl_q = 1'b0;
				end
				if (t >= 2) begin
					scl_q = 1'b1;
					shift_reg = {shift_reg[6:0], r.sda_in};
					tick_cnt = '0;
					if (bit_cnt >= 7) begin
						eng_phase = ENG_RACK;
						bit_cnt = '0;
					end else bit_cnt++;
				end else tick_cnt = t + 8'd1;
			end
			ENG_RACK: begin
				if (t == 0) begin
					scl_q = 1'b0;
					drv_q = 1'b1;
					sda_q = !ack_sel;
				end else if (t == 2) scl_q = 1'b1;
				if (t >= 4) begin
					scl_q = 1'b0;
					read_byte = shift_reg;
					end_command();
				end else tick_cnt = t + 8'd1;
			end
			default: ;
		endcase
		o.scl = scl_q;
		o.sda_level = sda_q;
		o.sda_drive = drv_q;
		o.done_res = done_flag;
		o.read_data = read_byte;
		o.ack_failed = ack_fail;
		return o;
	endfunction

	// send one tick and record its predicted outcome once accepted
	task automatic send_tick(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_bus_q.push_back(step_engine(r));
		ticks_sent++;
	endtask

	task automatic idle_ticks(input int n);
		req_t r;
		repeat (n) begin
			r.cmd_valid = 1'b0;
			r.opcode = 3'($urandom_range(7));
			r.write_data = 8'($urandom);
			r.send_ack = 1'($urandom_range(1));
			r.sda_in = 1'($urandom_range(1));
			send_tick(r);
		end
	endtask

	// issue one command and keep ticking until the engine is idle again;
	// high_polls sets how many SDA polls stay high during an ack wait
	task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input logic ack,
			input int high_polls, input bit noisy);
		req_t r;
		int k;
		k = 0;
		do begin
			r.cmd_valid = (k == 0) ? 1'b1 : (noisy ? 1'($urandom_range(1)) : 1'b0);
			r.opcode = (k == 0) ? op : 3'($urandom_range(7));
			r.write_data = (k == 0) ? data : 8'($urandom);
			r.send_ack = (k == 0) ? ack : 1'($urandom_range(1));
			if (op == OP_WACK && k >= 2) r.sda_in = (k - 2 < high_polls);
			else r.sda_in = 1'($urandom_range(1));
			send_tick(r);
			k++;
		end while (eng_phase != ENG_IDLE);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_bus_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_ack_limit(input logic [7:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		ack_limit = v;
	endtask

	task automatic test_reset_state();
		idle_ticks(4);
	endtask

	task automatic test_start_stop();
		run_cmd(OP_START, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(OP_STOP, 8'h00, 1'b0, 0, 1'b0);
	endtask

	task automatic test_write_byte();
		run_cmd(OP_WRITE, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(OP_WRITE, 8'hFF, 1'b1, 0, 1'b0);
	endtask

	task automatic test_read_byte();
		run_cmd(OP_READ, 8'h00, 1'b1, 0, 1'b0);
		run_cmd(OP_READ, 8'hFF, 1'b0, 0, 1'b0);
	endtask

	task automatic test_ack_wait();
		run_cmd(OP_WACK, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(OP_WACK, 8'h00, 1'b0, 5, 1'b0);
		// never acked: times out at the reset limit, flag must stick
		run_cmd(OP_WACK, 8'h00, 1'b0, 1000, 1'b0);
		idle_ticks(3);
		run_cmd(OP_START, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(OP_WACK, 8'h00, 1'b0, 2, 1'b0);
	endtask

	task automatic test_dropped_cmds();
		run_cmd(3'd5, 8'h12, 1'b1, 0, 1'b0);
		run_cmd(3'd6, 8'h34, 1'b0, 0, 1'b0);
		run_cmd(3'd7, 8'h56, 1'b1, 0, 1'b0);
		run_cmd(OP_WRITE, 8'h3C, 1'b0, 0, 1'b1);
		run_cmd(OP_READ, 8'h00, 1'b1, 0, 1'b1);
	endtask

	task automatic test_ack_limits();
		set_ack_limit(8'd0);
		run_cmd(OP_WACK, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(OP_WACK, 8'h00, 1'b0, 1, 1'b0);
		// the fail tick pins the full limit of 255 without any wrap
		set_ack_limit(8'd255);
		run_cmd(OP_WACK, 8'h00, 1'b0, 256, 1'b0);
	endtask

	task automatic test_backpressure();
		set_ack_limit(8'd3);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rx_hold = 300;
		run_cmd(OP_START, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(OP_WRITE, 8'hC3, 1'b0, 0, 1'b0);
		run_cmd(OP_WACK, 8'h00, 1'b0, 4, 1'b0);
		// pause until every result is back, then continue
		wait_drained();
		run_cmd(OP_READ, 8'h00, 1'b1, 0, 1'b0);
	endtask

	task automatic test_random(input int tx_idle, input int rx_idle);
		int first;
		int sel;
		int polls;
		logic [2:0] op;
		set_ack_limit(8'($urandom_range(12)));
		send_idle_pct = tx_idle;
		recv_stall_pct = rx_idle;
		first = ticks_sent;
		while (ticks_sent - first < RANDOM_TICKS) begin
			sel = $urandom_range(99);
			if (sel < 82) begin
				op = 3'($urandom_range(4));
				polls = ($urandom_range(9) < 3) ? ack_limit + 1 : $urandom_range(ack_limit);
				run_cmd(op, 8'($urandom), 1'($urandom_range(1)), polls,
					$urandom_range(3) == 0);
			end else if (sel < 94) begin
				idle_ticks($urandom_range(1, 4));
			end else begin
				run_cmd(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom_range(1)), 0,
					1'b0);
			end
		end
	endtask

	// receiver: random stalls, or a counted hold when one is requested
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rsp_stall <= 1'b1;
			rx_hold--;
		end else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_bus_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("rsp transaction with nothing expected: %p", rsp);
			end else begin
				want = expected_bus_q.pop_front();
				if (rsp.scl !== want.scl || rsp.sda_level !== want.sda_level ||
						rsp.sda_drive !== want.sda_drive || rsp.busy_res !== want.busy_res ||
						rsp.done_res !== want.done_res || rsp.read_data !== want.read_data ||
						rsp.ack_failed !== want.ack_failed) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch at %0t: exp scl=%b sda=%b drv=%b busy=%b done=%b rd=%h fail=%b",
							$realtime, want.scl, want.sda_level, want.sda_drive,
							want.busy_res, want.done_res, want.read_data, want.ack_failed,
							"\n                 got scl=%b sda=%b drv=%b busy=%b done=%b rd=%h fail=%b",
							rsp.scl, rsp.sda_level, rsp.sda_drive,
							rsp.busy_res, rsp.done_res, rsp.read_data, rsp.ack_failed);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		eng_phase = ENG_IDLE;
		tick_cnt = '0;
		bit_cnt = '0;
		shift_reg = '0;
		poll_cnt = '0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		drv_q = 1'b1;
		ack_sel = 1'b0;
		read_byte = '0;
		ack_fail = 1'b0;
		done_flag = 1'b0;
		ack_limit = ACK_TIMEOUT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_start_stop();
		test_write_byte();
		test_read_byte();
		test_ack_wait();
		test_dropped_cmds();
		test_ack_limits();
		test_backpressure();
		test_random(31, 82);
		test_random(82, 31);
		test_random(0, 0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[i2c_master_byte_engine.f]
design/i2cm_pkg.sv
design/i2cm_engine.sv
design/i2c_master_byte_engine.sv
design/i2cm_checker.sv
verif/tb_i2c_master_byte_engine.sv
